// File: design/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types for greedy box NMS: the layout of one kept-store entry.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int CoordW = 16;
  localparam int AreaW  = 34;

  typedef struct packed {
    logic signed [AreaW-1:0]  area;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
  } gbn_entry_t;

endpackage

// File: design/greedy_box_nms.sv
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy IoU non-maximum suppression over score-sorted boxes.
//
//   channel | dir | handshake            | word
//   s_      | in  | s_tvalid / s_tready  | tdata: top, left, bottom, right; tuser: first_of_set
//   m_      | out | m_tvalid / m_tready  | tdata: keep, kept_slot[5:0], store_overflow
//   cfg_    | in  | cfg_valid / cfg_ready| data: iou_threshold
//
// A box is compared with the kept boxes in store order; a new box is accepted only
// after the last one leaves its final step (no store write when suppressed).
// Each comparison is five steps through the single shared multiplier and the
// store read port.
// Synchronous active-high reset clears the threshold to 0.4 and the store count.
// The result sits in an output register; a stalled m_ side holds the box
// in its final step until the register frees.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
  parameter int MAX_KEPT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // top, left, bottom, right
  input  logic        s_tuser,   // first_of_set
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // keep, kept_slot[5:0], store_overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import gbn_pkg::*;

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_AREA   = 10'b0000000010,
    S_LOAD   = 10'b0000000100,
    S_FETCH  = 10'b0000001000,
    S_INTER  = 10'b0000010000,
    S_UNION  = 10'b0000100000,
    S_THRESH = 10'b0001000000,
    S_DECIDE = 10'b0010000000,
    S_WRITE  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state;

  logic [15:0]        thr;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic signed [15:0] bt, bl, bb, br;
  logic signed [33:0] area;
  logic signed [33:0] inter;
  logic signed [35:0] uni;
  logic signed [53:0] prod;
  logic               disj;
  logic               keep_r;
  logic               ovf_r;
  logic [5:0]         slot_r;

  gbn_entry_t rd_data;
  gbn_entry_t wr_data;
  logic       wr_en;
  logic       rd_en;

  logic signed [16:0] in_w, in_h, kw, kh;
  logic signed [15:0] min_r, max_l, min_b, max_t;
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;
  logic signed [33:0] inter_v;
  logic signed [53:0] lhs;
  logic               over;
  logic               disj_v;
  logic [CW-1:0]      idx_inc;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign in_w = {br[15], br} - {bl[15], bl};
  assign in_h = {bb[15], bb} - {bt[15], bt};

  assign min_r = (br < rd_data.right)  ? br : rd_data.right;
  assign max_l = (bl > rd_data.left)   ? bl : rd_data.left;
  assign min_b = (bb < rd_data.bottom) ? bb : rd_data.bottom;
  assign max_t = (bt > rd_data.top)    ? bt : rd_data.top;
  assign kw = {min_r[15], min_r} - {max_l[15], max_l};
  assign kh = {min_b[15], min_b} - {max_t[15], max_t};
  assign disj_v = (bt > rd_data.bottom) || (bb < rd_data.top) ||
                  (bl > rd_data.right)  || (br < rd_data.left);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_AREA: begin
        mul_a = 36'(in_w);
        mul_b = 18'(in_h);
      end
      S_INTER: begin
        mul_a = 36'(kw);
        mul_b = 18'(kh);
      end
      S_THRESH: begin
        mul_a = uni;
        mul_b = signed'({2'b00, thr});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign inter_v = disj ? 34'sd0 : signed'(prod[33:0]);
  assign lhs     = 54'(signed'({inter, 16'h0000}));
  assign idx_inc = idx + 1'b1;

  always_comb begin
    if (uni > 0) begin
      over = lhs > prod;
    end else if (uni < 0) begin
      over = lhs < prod;
    end else begin
      over = inter > 0;
    end
  end

  assign rd_en   = (state == S_FETCH);
  assign wr_en   = (state == S_WRITE) && (count < CW'(MAX_KEPT));
  assign wr_data = '{area: area, right: br, bottom: bb, left: bl, top: bt};

  gbn_store #(
    .DEPTH(MAX_KEPT),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd26214;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            bt <= signed'(s_tdata[15:0]);
            bl <= signed'(s_tdata[31:16]);
            bb <= signed'(s_tdata[47:32]);
            br <= signed'(s_tdata[63:48]);
            if (s_tuser) begin
              count <= '0;
            end
            state <= S_AREA;
          end
        end
        S_AREA: begin
          prod  <= mul_p;
          state <= S_LOAD;
        end
        S_LOAD: begin
          area  <= signed'(prod[33:0]);
          idx   <= '0;
          state <= (count == '0) ? S_WRITE : S_FETCH;
        end
        S_FETCH: begin
          state <= S_INTER;
        end
        S_INTER: begin
          prod  <= mul_p;
          disj  <= disj_v;
          state <= S_UNION;
        end
        S_UNION: begin
          inter <= inter_v;
          uni   <= 36'(area) + 36'(rd_data.area) - 36'(inter_v);
          state <= S_THRESH;
        end
        S_THRESH: begin
          prod  <= mul_p;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (over) begin
            keep_r <= 1'b0;
            slot_r <= '0;
            ovf_r  <= 1'b0;
            state  <= S_FINISH;
          end else begin
            idx   <= idx_inc;
            state <= (idx_inc == count) ? S_WRITE : S_FETCH;
          end
        end
        S_WRITE: begin
          keep_r <= 1'b1;
          if (count < CW'(MAX_KEPT)) begin
            count  <= count + 1'b1;
            slot_r <= 6'(count);
            ovf_r  <= 1'b0;
          end else begin
            slot_r <= '0;
            ovf_r  <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {ovf_r, slot_r, keep_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEPT))
    else $error("store count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready while a box is in work");

  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[6:1] == 6'd0 && !m_tdata[7]))
    else $error("suppressed box with slot or overflow set");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && count < CW'(MAX_KEPT)) |=> count == $past(count) + 1'b1)
    else $error("store write without count step");
`endif

endmodule

// File: design/gbn_store.sv
// ----------------------------------------------------------------------------
// gbn_store
// Kept-box store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbn_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  gbn_pkg::gbn_entry_t wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output gbn_pkg::gbn_entry_t rd_data
);
  import gbn_pkg::*;

  gbn_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
